/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files of the console block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants of the text console cursor writer.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int POS_W    = 14;
    localparam int CH_W     = 8;
    localparam int COLOR_W  = 24;
    localparam int GEO_W    = 8;
    localparam int CURSOR_W = 13;
    localparam int SCROLL_W = 14;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 24;
    localparam int TAB_STOP = 4;

    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT      = 8'h0B;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0] BLANK_CHAR = 8'h20;

    localparam logic [GEO_W-1:0]   RST_COLUMNS     = 8'd80;
    localparam logic [GEO_W-1:0]   RST_ROWS        = 8'd25;
    localparam logic [COLOR_W-1:0] RST_TEXT_COLOR  = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] RST_PAPER_COLOR = 24'h000000;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [CFG_IW-1:0] {
        CFG_COLUMNS     = 3'd0,
        CFG_ROWS        = 3'd1,
        CFG_TEXT        = 3'd2,
        CFG_PAPER       = 3'd3,
        CFG_BLANK_TEXT  = 3'd4,
        CFG_BLANK_PAPER = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_action           action;
        logic [CH_W-1:0]   character;
        logic              advance;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [SCROLL_W-1:0] rows_scrolled;
        logic                read_valid;
        logic [CH_W-1:0]     cell_character;
        logic [COLOR_W-1:0]  cell_text_colour;
        logic [COLOR_W-1:0]  cell_paper_colour;
    } t_out_item;

    typedef struct packed {
        logic [CH_W-1:0]    character;
        logic [COLOR_W-1:0] text_colour;
        logic [COLOR_W-1:0] paper_colour;
    } t_cell;

    typedef struct packed {
        logic [GEO_W-1:0]   columns;
        logic [GEO_W-1:0]   rows;
        logic [COLOR_W-1:0] text_colour;
        logic [COLOR_W-1:0] paper_colour;
        logic [COLOR_W-1:0] blank_text_colour;
        logic [COLOR_W-1:0] blank_paper_colour;
        logic               geo_dirty;
    } t_cfg;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_GEO_DIV,
        S_GEO_CELLS,
        S_COL,
        S_TARGET,
        S_CHECK,
        S_OVF_DIV,
        S_OVF_MUL,
        S_OVF_SUB,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } t_sweep;

endpackage

/* rtl/core/tcc_ram.sv */
// ----------------------------------------------------------------------------
// tcc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcc_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tcc_div.sv */
// ----------------------------------------------------------------------------
// tcc_div
// Restoring divider, one quotient bit per cycle, by an 8-bit divisor.
// ----------------------------------------------------------------------------
module tcc_div #(
    parameter int DW = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    input  logic [tcc_pkg::GEO_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DW-1:0]              o_quo,
    output logic [tcc_pkg::GEO_W-1:0]  o_rem
);
    import tcc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DW-1:0]     r_quo, n_quo;
    logic [GEO_W-1:0]  r_rem, n_rem;
    logic [GEO_W-1:0]  r_dvs, n_dvs;

    logic [GEO_W:0]    shifted;
    logic [GEO_W:0]    trial;
    logic              fits;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? trial[GEO_W-1:0] : shifted[GEO_W-1:0];
            n_quo = {r_quo[DW-2:0], fits};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

/* rtl/core/tcc_cfg.sv */
// ----------------------------------------------------------------------------
// tcc_cfg
// Configuration registers; flags the geometry stale after a size write.
// ----------------------------------------------------------------------------
module tcc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcc_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [tcc_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_geo_ack,
    output tcc_pkg::t_cfg               o_cfg
);
    import tcc_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_geo_ack) begin
            n_cfg.geo_dirty = 1'b0;
        end
        if (wr) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: begin
                    n_cfg.columns   = i_cfg_data[GEO_W-1:0];
                    n_cfg.geo_dirty = 1'b1;
                end
                CFG_ROWS: begin
                    n_cfg.rows      = i_cfg_data[GEO_W-1:0];
                    n_cfg.geo_dirty = 1'b1;
                end
                CFG_TEXT:        n_cfg.text_colour        = i_cfg_data[COLOR_W-1:0];
                CFG_PAPER:       n_cfg.paper_colour       = i_cfg_data[COLOR_W-1:0];
                CFG_BLANK_TEXT:  n_cfg.blank_text_colour  = i_cfg_data[COLOR_W-1:0];
                CFG_BLANK_PAPER: n_cfg.blank_paper_colour = i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns            <= RST_COLUMNS;
            r_cfg.rows               <= RST_ROWS;
            r_cfg.text_colour        <= RST_TEXT_COLOR;
            r_cfg.paper_colour       <= RST_PAPER_COLOR;
            r_cfg.blank_text_colour  <= RST_TEXT_COLOR;
            r_cfg.blank_paper_colour <= RST_PAPER_COLOR;
            r_cfg.geo_dirty          <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/text_console_cursor_writer.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Character-cell console: cell RAM, cursor, control bytes and scroll-up.
//
//   channel | dir | handshake              | word
//   --------+-----+------------------------+---------------------------
//   in      | in  | i_in_valid / o_in_stall   | t_in_item (action, cell)
//   out     | out | o_out_valid / i_out_stall | t_out_item (cursor, read)
//   cfg     | in  | i_cfg_valid / o_cfg_ready | index + 24-bit data
//
// Tab, carriage return and newline also pass through the serial divider.
// Scroll: a divide as well when overflow exceeds one row, then a
//   read-modify-write sweep of the active cells, one cell a cycle.
// Clear screen: a sweep of all MAX_CELLS cells. Reset: a clearing pass
//   over MAX_CELLS cells, then geometry setup; a columns or rows write redoes it.
// The result register lets the next word in while a result is stalled.
// ----------------------------------------------------------------------------
module text_console_cursor_writer #(
    parameter int MAX_CELLS = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  tcc_pkg::t_in_item           i_in,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output tcc_pkg::t_out_item          o_out,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcc_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [tcc_pkg::CFG_DW-1:0]  i_cfg_data
);
    import tcc_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int NW = $clog2(MAX_CELLS + 1);
    localparam int TW = ((NW > POS_W) ? NW : POS_W) + 1;
    localparam int PW = TW + GEO_W;

    t_cfg             cfg;
    logic             geo_ack;

    t_state           r_state, n_state;
    t_sweep           r_mode, n_mode;
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [GEO_W-1:0] r_c, n_c;
    logic [GEO_W-1:0] r_r, n_r;
    logic [NW-1:0]    r_cells, n_cells;
    t_action          r_act, n_act;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic             r_adv, n_adv;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [GEO_W-1:0] r_col, n_col;
    logic [TW-1:0]    r_t, n_t;
    logic [TW-1:0]    r_k, n_k;
    logic [PW-1:0]    r_prod, n_prod;
    logic [GEO_W-1:0] r_s, n_s;
    logic [NW-1:0]    r_keep, n_keep;
    logic [NW-1:0]    r_from, n_from;
    logic [NW-1:0]    r_limit, n_limit;
    logic [NW-1:0]    r_idx, n_idx;
    logic             r_pipe_v, n_pipe_v;
    logic [AW-1:0]    r_pipe_idx, n_pipe_idx;
    logic             r_pipe_copy, n_pipe_copy;
    t_cell            r_rd, n_rd;
    logic             r_rd_valid, n_rd_valid;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_cell            ram_wdata;
    logic [AW-1:0]    ram_raddr;
    t_cell            ram_rdata;

    logic             div_start;
    logic [TW-1:0]    div_dividend;
    logic [GEO_W-1:0] div_divisor;
    logic             div_done;
    logic [TW-1:0]    div_quo;
    logic [GEO_W-1:0] div_rem;

    logic [GEO_W-1:0] c_eff;
    logic [GEO_W-1:0] geo_rows;
    logic [TW-1:0]    geo_maxr;
    logic [TW-1:0]    ovf_diff;
    logic             need_col;
    t_cell            blank_cell;

    tcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_geo_ack   (geo_ack),
        .o_cfg       (cfg)
    );

    tcc_div #(.DW(TW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    tcc_ram #(.WIDTH($bits(t_cell)), .DEPTH(MAX_CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Column count: zero counts as one, never more than the store.
    always_comb begin
        c_eff = (cfg.columns == '0) ? GEO_W'(1) : cfg.columns;
        if (32'(c_eff) > MAX_CELLS) begin
            c_eff = GEO_W'(MAX_CELLS);
        end
    end

    assign geo_rows = (cfg.rows == '0) ? GEO_W'(1) : cfg.rows;
    assign geo_maxr = (div_quo == '0) ? TW'(1) : div_quo;
    assign ovf_diff = r_t - TW'(r_cells);
    assign need_col = (i_in.character == CH_TAB) || (i_in.character == CH_CR)
                   || (i_in.character == CH_LF);

    always_comb begin
        if (r_mode == SW_INIT) begin
            blank_cell.character    = BLANK_CHAR;
            blank_cell.text_colour  = RST_TEXT_COLOR;
            blank_cell.paper_colour = RST_PAPER_COLOR;
        end else begin
            blank_cell.character    = BLANK_CHAR;
            blank_cell.text_colour  = cfg.blank_text_colour;
            blank_cell.paper_colour = cfg.blank_paper_colour;
        end
    end

    assign o_in_stall = !((r_state == S_IDLE) && !cfg.geo_dirty);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cursor    = r_cursor;
        n_c         = r_c;
        n_r         = r_r;
        n_cells     = r_cells;
        n_act       = r_act;
        n_ch        = r_ch;
        n_adv       = r_adv;
        n_pos       = r_pos;
        n_col       = r_col;
        n_t         = r_t;
        n_k         = r_k;
        n_prod      = r_prod;
        n_s         = r_s;
        n_keep      = r_keep;
        n_from      = r_from;
        n_limit     = r_limit;
        n_idx       = r_idx;
        n_pipe_v    = r_pipe_v;
        n_pipe_idx  = r_pipe_idx;
        n_pipe_copy = r_pipe_copy;
        n_rd        = r_rd;
        n_rd_valid  = r_rd_valid;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        geo_ack      = 1'b0;
        div_start    = 1'b0;
        div_dividend = TW'(r_cursor);
        div_divisor  = r_c;

        ram_raddr = AW'(r_from + r_idx);
        ram_we    = r_pipe_v;
        ram_waddr = r_pipe_idx;
        ram_wdata = r_pipe_copy ? ram_rdata : blank_cell;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cfg.geo_dirty) begin
                    geo_ack      = 1'b1;
                    n_c          = c_eff;
                    div_start    = 1'b1;
                    div_dividend = TW'(MAX_CELLS);
                    div_divisor  = c_eff;
                    n_state      = S_GEO_DIV;
                end else if (i_in_valid) begin
                    n_act      = i_in.action;
                    n_ch       = i_in.character;
                    n_adv      = i_in.advance;
                    n_pos      = i_in.position;
                    n_k        = '0;
                    n_rd       = '0;
                    n_rd_valid = 1'b0;
                    unique case (i_in.action)
                        ACT_PUT: begin
                            if (need_col) begin
                                div_start = 1'b1;
                                n_state   = S_COL;
                            end else begin
                                n_state = S_TARGET;
                            end
                        end
                        ACT_SET: n_state = S_TARGET;
                        ACT_READ: begin
                            if (32'(i_in.position) < MAX_CELLS) begin
                                n_state = S_RD_ADDR;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_mode  = SW_CLEAR;
                            n_idx   = '0;
                            n_keep  = '0;
                            n_limit = NW'(MAX_CELLS);
                            n_state = S_SWEEP;
                        end
                    endcase
                end
            end

            S_GEO_DIV: begin
                if (div_done) begin
                    n_r     = (TW'(geo_rows) > geo_maxr) ? GEO_W'(geo_maxr) : geo_rows;
                    n_state = S_GEO_CELLS;
                end
            end

            S_GEO_CELLS: begin
                n_cells = NW'((2 * GEO_W)'(r_c) * (2 * GEO_W)'(r_r));
                n_state = S_IDLE;
            end

            S_COL: begin
                if (div_done) begin
                    n_col   = div_rem;
                    n_state = S_TARGET;
                end
            end

            S_TARGET: begin
                n_state = S_CHECK;
                if (r_act == ACT_SET) begin
                    n_t = TW'(r_pos);
                end else begin
                    case (r_ch)
                        CH_TAB: n_t = TW'(r_cursor) + TW'(TAB_STOP) - TW'(r_col % TAB_STOP);
                        CH_VT:  n_t = TW'(r_cursor) + TW'(r_c);
                        CH_CR:  n_t = TW'(r_cursor) - TW'(r_col);
                        CH_LF:  n_t = TW'(r_cursor) - TW'(r_col) + TW'(r_c);
                        default: begin
                            // Write the byte at the cursor, then step by advance.
                            n_t                    = TW'(r_cursor) + TW'(r_adv);
                            ram_we                 = 1'b1;
                            ram_waddr              = r_cursor;
                            ram_wdata.character    = r_ch;
                            ram_wdata.text_colour  = cfg.text_colour;
                            ram_wdata.paper_colour = cfg.paper_colour;
                        end
                    endcase
                end
            end

            S_CHECK: begin
                if (r_t < TW'(r_cells)) begin
                    n_cursor = AW'(r_t);
                    n_state  = S_DONE;
                end else if (ovf_diff < TW'(r_c)) begin
                    n_k     = TW'(1);
                    n_state = S_OVF_MUL;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = ovf_diff;
                    n_state      = S_OVF_DIV;
                end
            end

            S_OVF_DIV: begin
                if (div_done) begin
                    n_k     = div_quo + TW'(1);
                    n_state = S_OVF_MUL;
                end
            end

            S_OVF_MUL: begin
                n_prod  = PW'(r_k) * PW'(r_c);
                n_s     = (r_k < TW'(r_r)) ? GEO_W'(r_k) : r_r;
                n_state = S_OVF_SUB;
            end

            S_OVF_SUB: begin
                n_cursor = AW'(r_t - TW'(r_prod));
                n_keep   = NW'((2 * GEO_W)'(r_r - r_s) * (2 * GEO_W)'(r_c));
                n_from   = NW'((2 * GEO_W)'(r_s) * (2 * GEO_W)'(r_c));
                n_limit  = r_cells;
                n_idx    = '0;
                n_mode   = SW_SCROLL;
                n_state  = S_SWEEP;
            end

            S_SWEEP: begin
                // Read cell from+idx now, write cell idx next cycle.
                if (r_idx < r_limit) begin
                    n_idx       = r_idx + NW'(1);
                    n_pipe_v    = 1'b1;
                    n_pipe_idx  = r_idx[AW-1:0];
                    n_pipe_copy = (r_idx < r_keep);
                end else begin
                    n_pipe_v = 1'b0;
                    n_state  = (r_mode == SW_INIT) ? S_IDLE : S_DONE;
                end
            end

            S_RD_ADDR: begin
                ram_raddr = AW'(r_pos);
                n_state   = S_RD_DATA;
            end

            S_RD_DATA: begin
                n_rd       = ram_rdata;
                n_rd_valid = 1'b1;
                n_state    = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out.cursor_cell       = CURSOR_W'(r_cursor);
                    n_out.rows_scrolled     = SCROLL_W'(r_k);
                    n_out.read_valid        = r_rd_valid;
                    n_out.cell_character    = r_rd.character;
                    n_out.cell_text_colour  = r_rd.text_colour;
                    n_out.cell_paper_colour = r_rd.paper_colour;
                    n_state                 = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_mode      <= SW_INIT;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_limit     <= NW'(MAX_CELLS);
            r_keep      <= '0;
            r_from      <= '0;
            r_pipe_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cursor    <= n_cursor;
            r_idx       <= n_idx;
            r_limit     <= n_limit;
            r_keep      <= n_keep;
            r_from      <= n_from;
            r_pipe_v    <= n_pipe_v;
            r_out_valid <= n_out_valid;
        end
        r_c         <= n_c;
        r_r         <= n_r;
        r_cells     <= n_cells;
        r_act       <= n_act;
        r_ch        <= n_ch;
        r_adv       <= n_adv;
        r_pos       <= n_pos;
        r_col       <= n_col;
        r_t         <= n_t;
        r_k         <= n_k;
        r_prod      <= n_prod;
        r_s         <= n_s;
        r_pipe_idx  <= n_pipe_idx;
        r_pipe_copy <= n_pipe_copy;
        r_rd        <= n_rd;
        r_rd_valid  <= n_rd_valid;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/core/tcc_chk.sv */
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks of the text console cursor writer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input tcc_pkg::t_out_item  o_out,
    input logic                i_out_stall
);
    import tcc_pkg::*;

    // Hold a stalled result word.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result word changed")

    // One word at a time: the block is busy right after taking a word.
    `ASSERT_NXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken twice in a row")

    `ASSERT_IMP(a_read_empty, i_clk, i_rst_n, o_out_valid && !o_out.read_valid, (o_out.cell_character == '0) && (o_out.cell_text_colour == '0) && (o_out.cell_paper_colour == '0), "cell fields set without a read")

    `ASSERT_IMP(a_read_noscroll, i_clk, i_rst_n, o_out_valid && o_out.read_valid, o_out.rows_scrolled == '0, "read word reports a scroll")

endmodule

bind text_console_cursor_writer tcc_chk u_tcc_chk (.*);
